>>> design/sem_pkg.sv
// Shared widths, tap indexes and lane control type for the Sobel edge magnitude block.
package sem_pkg;

   localparam int PIXEL_W    = 24;               // one packed RGB pixel
   localparam int CHAN_W     = 8;                // one color channel
   localparam int NUM_CH     = 3;                // blue, green, red lanes
   localparam int NUM_WIN    = 9;                // pixels in the 3x3 window
   localparam int NUM_TAPS   = 8;                // window pixels with nonzero weight
   localparam int GRAD_W     = 11;               // signed gradient, -1020..1020
   localparam int SQ_W       = 20;               // square of a gradient
   localparam int SUM_W      = SQ_W + 1;         // gx^2 + gy^2
   localparam int EDGE_W     = 8;                // result width
   localparam int REM_W      = 2 * EDGE_W;       // radicand that still yields an unclipped root
   localparam int ROOT_W     = REM_W;            // partial root during the digit steps
   localparam int ROOT_STEPS = EDGE_W;           // one root bit per step
   localparam int NUM_STAGES = 3 + ROOT_STEPS;   // gradient, square, sum, root steps

   localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

   // Tap order inside a lane window (center pixel carries no weight)
   localparam int TAP_TL = 0;
   localparam int TAP_TM = 1;
   localparam int TAP_TR = 2;
   localparam int TAP_ML = 3;
   localparam int TAP_MR = 4;
   localparam int TAP_BL = 5;
   localparam int TAP_BM = 6;
   localparam int TAP_BR = 7;

   typedef logic [NUM_TAPS-1:0][CHAN_W-1:0] taps_type;

   typedef struct packed {
      logic                  grad_en;
      logic                  sq_en;
      logic                  sum_en;
      logic [ROOT_STEPS-1:0] root_en;
   } lane_ctrl_type;

endpackage

>>> design/sobel_edge_magnitude_rgb.sv
// Top level of the Sobel edge magnitude block over one 3x3 RGB window.
//
// Each accepted beat carries a full 3x3 window of 24-bit RGB pixels and yields
// exactly one result beat: the largest per-channel Sobel magnitude
// floor(sqrt(gx^2 + gy^2)), saturated to 255, with rsp_tuser set when the
// true magnitude exceeded 255. Three channel lanes run side by side and a
// merge stage takes their maximum. The block sustains one beat per clock while
// the output is taken; an accepted beat passes the gradient, square, sum and
// eight root-digit stages in each lane, then the merge register. The root
// digit stages set the depth: one root bit is resolved per stage. Every stage
// holds its beat only while the stage after it is full and stalled, so the
// pipeline keeps taking beats while a result waits at the output. The block
// holds no state across windows; the center pixel does not affect the result.
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // top_left, top_mid, top_right, mid_left, center, mid_right,
   // bottom_left, bottom_mid, bottom_right; 24 bits each, lowest first
   input  logic [NUM_WIN*PIXEL_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // edge_value [7:0]
   output logic [EDGE_W-1:0]          rsp_tdata,
   // clipped [0]
   output logic                       rsp_tuser
);

   // window position of each lane tap in req_tdata
   localparam int WIN_POS [NUM_TAPS] = '{0, 1, 2, 3, 5, 6, 7, 8};

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   ready;
   logic                  out_valid_ff, out_valid_in;
   lane_ctrl_type         ctrl;

   logic [NUM_CH-1:0][EDGE_W-1:0] lane_root;
   logic [NUM_CH-1:0]             lane_clip;
   taps_type                      lane_taps [NUM_CH];

   // a stage may load when it is empty or its contents move on this cycle
   always_comb begin
      ready[NUM_STAGES] = !out_valid_ff || rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_tready = ready[0];

   always_comb begin
      valid_in     = valid_ff;
      out_valid_in = out_valid_ff;
      if (ready[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
      if (ready[NUM_STAGES]) begin
         out_valid_in = valid_ff[NUM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // advance each lane stage together with its valid bit
   assign ctrl.grad_en = ready[0];
   assign ctrl.sq_en   = ready[1];
   assign ctrl.sum_en  = ready[2];
   assign ctrl.root_en = ready[NUM_STAGES-1:3];

   for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
         assign lane_taps[c][t] = req_tdata[WIN_POS[t]*PIXEL_W + c*CHAN_W +: CHAN_W];
      end

      sem_lane u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .taps  (lane_taps[c]),
         .root  (lane_root[c]),
         .clip  (lane_clip[c])
      );
   end

   sem_merge u_merge (
      .clock      (clock),
      .en         (ready[NUM_STAGES]),
      .roots      (lane_root),
      .clips      (lane_clip),
      .edge_ff    (rsp_tdata),
      .clipped_ff (rsp_tuser)
   );

   assign rsp_tvalid = out_valid_ff;

   // a clipped result always reads as full scale
   a_clip_full : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == EDGE_MAX)
      else $error("clipped result is not full scale");

   // input stalls only when the output holds a beat that is not taken
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // an accepted beat lands in the first stage
   a_accept_load : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted beat lost at first stage");

   // a beat leaving the last lane stage reaches the output register
   a_drain_out : assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-1] && ready[NUM_STAGES] |=> rsp_tvalid)
      else $error("beat lost at merge stage");

endmodule

>>> design/sem_root_step.sv
// One registered digit step of the restoring integer square root.
module sem_root_step
   import sem_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              en,
   input  logic [REM_W-1:0]  rem_prev,
   input  logic [ROOT_W-1:0] root_prev,
   input  logic              clip_prev,
   output logic [REM_W-1:0]  rem_ff,
   output logic [ROOT_W-1:0] root_ff,
   output logic              clip_ff
);

   localparam logic [ROOT_W-1:0] STEP_BIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - STEP));

   logic [ROOT_W:0]   trial;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_in;

   always_comb begin
      trial = {1'b0, root_prev} + {1'b0, STEP_BIT};
      if ({1'b0, rem_prev} >= trial) begin
         rem_in  = rem_prev - trial[REM_W-1:0];
         root_in = (root_prev >> 1) + STEP_BIT;
      end else begin
         rem_in  = rem_prev;
         root_in = root_prev >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         clip_ff <= clip_prev;
      end
   end

endmodule

>>> design/sem_lane.sv
// One color lane: Sobel gradients, squares, sum and pipelined square root.
module sem_lane
   import sem_pkg::*;
(
   input  logic                clock,
   input  lane_ctrl_type       ctrl,
   input  taps_type            taps,
   output logic [EDGE_W-1:0]   root,
   output logic                clip
);

   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
   logic [SUM_W-1:0]         sum_in;
   logic [REM_W-1:0]         rem_ff;
   logic                     big_ff;

   logic [REM_W-1:0]  rem_chain  [ROOT_STEPS+1];
   logic [ROOT_W-1:0] root_chain [ROOT_STEPS+1];
   logic              clip_chain [ROOT_STEPS+1];

   function automatic logic signed [GRAD_W-1:0] ext(input logic [CHAN_W-1:0] v);
      ext = $signed({{(GRAD_W - CHAN_W){1'b0}}, v});
   endfunction

   // gx: rows {1,0,-1},{2,0,-2},{1,0,-1}; gy: rows {1,2,1},{0,0,0},{-1,-2,-1}
   always_comb begin
      gx_in = (ext(taps[TAP_TL]) - ext(taps[TAP_TR]))
            + ((ext(taps[TAP_ML]) - ext(taps[TAP_MR])) <<< 1)
            + (ext(taps[TAP_BL]) - ext(taps[TAP_BR]));
      gy_in = (ext(taps[TAP_TL]) + (ext(taps[TAP_TM]) <<< 1) + ext(taps[TAP_TR]))
            - (ext(taps[TAP_BL]) + (ext(taps[TAP_BM]) <<< 1) + ext(taps[TAP_BR]));
   end

   assign sqx_full = gx_ff * gx_ff;
   assign sqy_full = gy_ff * gy_ff;
   assign sum_in   = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (ctrl.grad_en) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (ctrl.sq_en) begin
         sqx_ff <= sqx_full[SQ_W-1:0];
         sqy_ff <= sqy_full[SQ_W-1:0];
      end
      // a radicand at or above 2^16 roots past 255: flag it, root the low bits
      if (ctrl.sum_en) begin
         rem_ff <= sum_in[REM_W-1:0];
         big_ff <= |sum_in[SUM_W-1:REM_W];
      end
   end

   assign rem_chain[0]  = rem_ff;
   assign root_chain[0] = '0;
   assign clip_chain[0] = big_ff;

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      sem_root_step #(
         .STEP (s)
      ) u_step (
         .clock     (clock),
         .en        (ctrl.root_en[s]),
         .rem_prev  (rem_chain[s]),
         .root_prev (root_chain[s]),
         .clip_prev (clip_chain[s]),
         .rem_ff    (rem_chain[s+1]),
         .root_ff   (root_chain[s+1]),
         .clip_ff   (clip_chain[s+1])
      );
   end

   assign root = root_chain[ROOT_STEPS][EDGE_W-1:0];
   assign clip = clip_chain[ROOT_STEPS];

endmodule

>>> design/sem_merge.sv
// Merge stage: largest lane magnitude, saturated, into the output register.
module sem_merge
   import sem_pkg::*;
(
   input  logic                         clock,
   input  logic                         en,
   input  logic [NUM_CH-1:0][EDGE_W-1:0] roots,
   input  logic [NUM_CH-1:0]            clips,
   output logic [EDGE_W-1:0]            edge_ff,
   output logic                         clipped_ff
);

   logic [EDGE_W-1:0] best;
   logic [EDGE_W-1:0] edge_in;

   always_comb begin
      best = roots[0];
      for (int c = 1; c < NUM_CH; c++) begin
         if (roots[c] > best) begin
            best = roots[c];
         end
      end
      edge_in = (|clips) ? EDGE_MAX : best;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         edge_ff    <= edge_in;
         clipped_ff <= |clips;
      end
   end

endmodule

>>> verif/sobel_edge_magnitude_rgb_tb.sv
// Self-checking testbench for the Sobel edge magnitude block over 3x3 RGB windows.
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_tb;
   import sem_pkg::*;

   // Window positions in req_tdata, row-major, top_left in the lowest pixel
   localparam int WIN_TL = 0;
   localparam int WIN_TM = 1;
   localparam int WIN_TR = 2;
   localparam int WIN_ML = 3;
   localparam int WIN_CC = 4;
   localparam int WIN_MR = 5;
   localparam int WIN_BL = 6;
   localparam int WIN_BM = 7;
   localparam int WIN_BR = 8;

   // Longest correct silence is a long sender gap plus a long receiver stall
   // plus the pipeline depth; allow far more.
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 2 * NUM_STAGES;
   localparam int MAX_REPORTS  = 10;

   typedef logic [NUM_WIN-1:0][PIXEL_W-1:0] window_type;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_value;
      logic              clipped;
   } edge_result_type;

   // Flavors of random window content
   typedef enum int {
      MIX_NOISE,     // every byte uniform: mostly saturated edges
      MIX_SMOOTH,    // small spread around a base: mostly unclipped magnitudes
      MIX_EXTREME    // bytes drawn from 0, 255 or random
   } window_mix_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // top_left, top_mid, top_right, mid_left, center, mid_right,
   // bottom_left, bottom_mid, bottom_right; 24 bits each, lowest first
   logic [NUM_WIN*PIXEL_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // edge_value [7:0]
   logic [EDGE_W-1:0]          rsp_tdata;
   // clipped [0]
   logic                       rsp_tuser;

   edge_result_type expected_edges[$];

   bit          send_gaps_on  = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   int          windows_sent;
   int          results_checked;
   int          clipped_seen;
   int          mismatches;
   int unsigned idle_cycles;

   sobel_edge_magnitude_rgb dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Floor of the square root: set root bits from the top while the square fits.
   // The largest radicand is 2 * 1020^2, so eleven root bits suffice.
   function automatic int floor_root(input int radicand);
      int root;
      root = 0;
      for (int b = 10; b >= 0; b--) begin
         if ((root | (1 << b)) * (root | (1 << b)) <= radicand) begin
            root = root | (1 << b);
         end
      end
      return root;
   endfunction

   // Expected beat for one window: max over the three channels of the
   // Sobel magnitude, saturated to EDGE_MAX with the clip flag.
   function automatic edge_result_type predict_edge(input window_type w);
      edge_result_type res;
      int              px [NUM_WIN];
      int              gx;
      int              gy;
      int              mag;
      int              best;
      best = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int k = 0; k < NUM_WIN; k++) begin
            px[k] = int'(w[k][ch*CHAN_W +: CHAN_W]);
         end
         gx = (px[WIN_TL] - px[WIN_TR]) + 2 * (px[WIN_ML] - px[WIN_MR])
            + (px[WIN_BL] - px[WIN_BR]);
         gy = (px[WIN_TL] + 2 * px[WIN_TM] + px[WIN_TR])
            - (px[WIN_BL] + 2 * px[WIN_BM] + px[WIN_BR]);
         mag = floor_root(gx * gx + gy * gy);
         if (mag > best) begin
            best = mag;
         end
      end
      res.clipped    = (best > int'(EDGE_MAX));
      res.edge_value = res.clipped ? EDGE_MAX : EDGE_W'(best);
      return res;
   endfunction

   // Idle length: mostly zero or short, now and then long.
   // A stall is never skipped, while a sender gap may be zero.
   function automatic int pick_idle(input bit enabled, input bit at_least_one);
      int r;
      if (!enabled) begin
         return at_least_one ? 1 : 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55 && !at_least_one) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic window_type random_window(input window_mix_type mix);
      window_type w;
      int         base;
      int         spread;
      int         v;
      int         pick;
      w = '0;
      case (mix)
         MIX_NOISE: begin
            for (int k = 0; k < NUM_WIN; k++) begin
               w[k] = PIXEL_W'($urandom);
            end
         end
         MIX_SMOOTH: begin
            // Keep spread low so most magnitudes stay below saturation
            spread = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 255)
                                                 : $urandom_range(0, 40);
            for (int ch = 0; ch < NUM_CH; ch++) begin
               base = $urandom_range(0, 255);
               for (int k = 0; k < NUM_WIN; k++) begin
                  v = base + int'($urandom_range(0, spread)) - spread / 2;
                  if (v < 0) v = 0;
                  if (v > 255) v = 255;
                  w[k][ch*CHAN_W +: CHAN_W] = CHAN_W'(v);
               end
            end
         end
         default: begin
            for (int k = 0; k < NUM_WIN; k++) begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  pick = $urandom_range(0, 2);
                  w[k][ch*CHAN_W +: CHAN_W] = (pick == 0) ? 8'h00 :
                                              (pick == 1) ? 8'hFF : CHAN_W'($urandom);
               end
            end
         end
      endcase
      return w;
   endfunction

   // Send one window beat. Call right after a rising edge. Drop tvalid only
   // when a gap is taken, so a back-to-back beat never sees tvalid lowered
   // and raised in the same step.
   task automatic send_window(input window_type w);
      int gap;
      gap = pick_idle(send_gaps_on, 1'b0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      expected_edges.push_back(predict_edge(w));
      windows_sent++;
   endtask

   task automatic test_directed_windows;
      window_type w;
      // Flat windows and a lone center pixel give no edge at all
      send_window('0);
      send_window({NUM_WIN{24'hFFFFFF}});
      w = '0; w[WIN_CC] = 24'hFFFFFF;
      send_window(w);
      // Full-scale gradients in each direction and sign saturate
      w = '0; w[WIN_TL] = 24'hFFFFFF; w[WIN_ML] = 24'hFFFFFF; w[WIN_BL] = 24'hFFFFFF;
      send_window(w);
      w = '0; w[WIN_TR] = 24'hFFFFFF; w[WIN_MR] = 24'hFFFFFF; w[WIN_BR] = 24'hFFFFFF;
      send_window(w);
      w = '0; w[WIN_TL] = 24'hFFFFFF; w[WIN_TM] = 24'hFFFFFF; w[WIN_TR] = 24'hFFFFFF;
      send_window(w);
      w = '0; w[WIN_BL] = 24'hFFFFFF; w[WIN_BM] = 24'hFFFFFF; w[WIN_BR] = 24'hFFFFFF;
      send_window(w);
      // Diagonal corner: both gradients at 765
      w = '0; w[WIN_TL] = 24'hFFFFFF; w[WIN_TM] = 24'hFFFFFF; w[WIN_ML] = 24'hFFFFFF;
      send_window(w);
      for (int ch = 0; ch < NUM_CH; ch++) begin
         // One channel alone carries a full edge
         w = '0;
         w[WIN_TL][ch*CHAN_W +: CHAN_W] = 8'hFF;
         w[WIN_ML][ch*CHAN_W +: CHAN_W] = 8'hFF;
         w[WIN_BL][ch*CHAN_W +: CHAN_W] = 8'hFF;
         send_window(w);
         // gx = 255, gy = 1: root is exactly 255, just below saturation
         w = '0;
         w[WIN_TL][ch*CHAN_W +: CHAN_W] = 8'd1;
         w[WIN_ML][ch*CHAN_W +: CHAN_W] = 8'd127;
         send_window(w);
      end
      // gx = 256, gy = 0: first saturating magnitude
      w = '0; w[WIN_TL] = 24'h010000; w[WIN_ML] = 24'h7F0000; w[WIN_BL] = 24'h010000;
      send_window(w);
      // Mirrored: gx = -255, gy = 1
      w = '0; w[WIN_TR] = 24'h000100; w[WIN_MR] = 24'h007F00;
      send_window(w);
      // Channels of opposite sign: blue wins with 128
      w = '0;
      w[WIN_TL] = 24'h102030; w[WIN_ML] = 24'h102030; w[WIN_BL] = 24'h102030;
      w[WIN_TR] = 24'h302010; w[WIN_MR] = 24'h302010; w[WIN_BR] = 24'h302010;
      send_window(w);
      // Small edge and checkerboards of alternating bits
      w = '0; w[WIN_TL] = 24'h010101; w[WIN_ML] = 24'h010101; w[WIN_BL] = 24'h010101;
      send_window(w);
      for (int k = 0; k < NUM_WIN; k++) w[k] = (k % 2 == 0) ? 24'hAAAAAA : 24'h555555;
      send_window(w);
      for (int k = 0; k < NUM_WIN; k++) w[k] = (k % 2 == 0) ? 24'h555555 : 24'hAAAAAA;
      send_window(w);
   endtask

   task automatic test_noise_windows(input int count);
      repeat (count) send_window(random_window(MIX_NOISE));
   endtask

   task automatic test_smooth_windows(input int count);
      repeat (count) send_window(random_window(MIX_SMOOTH));
   endtask

   task automatic test_extreme_windows(input int count);
      repeat (count) send_window(random_window(MIX_EXTREME));
   endtask

   // Stream at full rate, first with an always-ready receiver, then with
   // backpressure so stalls land while the pipeline is full.
   task automatic test_full_rate(input int count);
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (count / 2) send_window(random_window(window_mix_type'($urandom_range(0, 2))));
      rsp_stalls_on = 1'b1;
      repeat (count / 2) send_window(random_window(window_mix_type'($urandom_range(0, 2))));
      send_gaps_on  = 1'b1;
   endtask

   // Receiver: ready for a random stretch, then stall for a random stretch
   initial begin : rsp_backpressure
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (rsp_stalls_on) begin
            rsp_tready <= 1'b0;
            repeat (pick_idle(1'b1, 1'b1)) @(posedge clock);
         end
      end
   end

   // Compare each result beat against the oldest expected edge
   always @(posedge clock) begin : result_check
      edge_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_edges.size() == 0) begin
            if (mismatches < MAX_REPORTS) begin
               $display("unexpected result beat: edge_value %0d clipped %0b",
                        rsp_tdata, rsp_tuser);
            end
            mismatches++;
         end else begin
            want = expected_edges.pop_front();
            results_checked++;
            if (want.clipped) clipped_seen++;
            if (rsp_tdata !== want.edge_value || rsp_tuser !== want.clipped) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("result %0d: expected edge_value %0d clipped %0b, got %0d %0b",
                           results_checked, want.edge_value, want.clipped,
                           rsp_tdata, rsp_tuser);
               end
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles without any accepted beat
   always @(posedge clock) begin : idle_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : run_tests
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_windows();
      test_noise_windows(300);
      test_smooth_windows(600);
      test_extreme_windows(150);
      test_full_rate(250);

      // Drain: wait for every expected edge, then let stray beats show up
      req_tvalid <= 1'b0;
      while (expected_edges.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d windows: directed edges, noise, smooth, extreme and full-rate",
               windows_sent);
      $display("compared %0d results, %0d of them saturated, %0d mismatches",
               results_checked, clipped_seen, mismatches);
      if (mismatches == 0 && expected_edges.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> files.f
design/sem_pkg.sv
design/sem_root_step.sv
design/sem_lane.sv
design/sem_merge.sv
design/sobel_edge_magnitude_rgb.sv
verif/sobel_edge_magnitude_rgb_tb.sv
